[rtl/core/mgd_pkg.sv]
// ============================================================================
// mgd_pkg
// Shared types, codes and the cell stencil sum for the grid divergence block.
// ============================================================================
package mgd_pkg;

    // Cell kinds carried in the input word.
    localparam logic [1:0] KIND_FLUID = 2'd0;
    localparam logic [1:0] KIND_WALL  = 2'd1;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_SIZE = 2'd2;

    // Grid size registers are 11 bits wide.
    localparam int CFG_SIZE_W = 11;
    localparam logic [CFG_SIZE_W-1:0] GRID_SIZE_RST     = 11'd64;
    localparam logic [31:0]           INV_CELL_SIZE_RST = 32'h0001_0000;

    // Width of a result position field.
    localparam int POS_W = 10;

    // The stencil sum of 32-bit velocities stays within 34 signed bits.
    localparam int SUM_W = 34;

    typedef struct packed {
        logic [1:0]         cell_kind;
        logic signed [31:0] face_vel_x;
        logic signed [31:0] face_vel_y;
    } t_in_word;

    typedef struct packed {
        logic [POS_W-1:0]   out_col;
        logic [POS_W-1:0]   out_row;
        logic signed [31:0] divergence;
        logic               frame_last;
    } t_out_word;

    // One line store entry: the previous row's cell and the kind one row older.
    typedef struct packed {
        logic [1:0]         older_kind;
        logic [1:0]         kind;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } t_line_word;

    // Unscaled divergence sum with the position it belongs to.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [POS_W-1:0]        col;
        logic [POS_W-1:0]        row;
        logic                    last;
    } t_div_req;

    // Face velocity differences of one cell, with wall corrections.
    // Non-fluid cells give zero.
    function automatic logic signed [SUM_W-1:0] cell_sum(
        input logic [1:0]         kind,
        input logic signed [31:0] vx,
        input logic signed [31:0] vy,
        input logic               has_l,
        input logic [1:0]         lk,
        input logic               has_r,
        input logic [1:0]         rk,
        input logic signed [31:0] rvx,
        input logic               has_d,
        input logic [1:0]         dk,
        input logic               has_u,
        input logic [1:0]         uk,
        input logic signed [31:0] uvy
    );
        logic signed [SUM_W-1:0] d;
        logic signed [SUM_W-1:0] ext_vx;
        logic signed [SUM_W-1:0] ext_vy;
        logic signed [SUM_W-1:0] ext_rvx;
        logic signed [SUM_W-1:0] ext_uvy;
        ext_vx  = SUM_W'(vx);
        ext_vy  = SUM_W'(vy);
        ext_rvx = SUM_W'(rvx);
        ext_uvy = SUM_W'(uvy);
        d = '0;
        if (has_l && lk == KIND_WALL) begin
            d = d + ext_vx;
        end
        if (has_r) begin
            if (rk == KIND_WALL) begin
                d = d - ext_vx;
            end else begin
                d = d + ext_rvx - ext_vx;
            end
        end
        if (has_d && dk == KIND_WALL) begin
            d = d + ext_vy;
        end
        if (has_u) begin
            if (uk == KIND_WALL) begin
                d = d - ext_vy;
            end else begin
                d = d + ext_uvy - ext_vy;
            end
        end
        if (kind != KIND_FLUID) begin
            d = '0;
        end
        return d;
    endfunction

endpackage

[rtl/core/mac_grid_divergence_stencil.sv]
// ============================================================================
// mac_grid_divergence_stencil
// Streaming divergence of a staggered velocity grid with line stores.
// ============================================================================
// Path: a result passes the sum register and the product and output registers
// of the scaling pipeline after the input word that completes its neighborhood
// is accepted, behind any result of the same word that goes ahead of it.
// Throughput: one word per cycle while the results drain without stall; in the
// last grid row each word after the first yields two results through the single
// scaling pipeline, and the final word yields 3, so the next word waits for them.
// Reset is synchronous: control state cleared, grid 64 x 64, scale 1.0; the
// line store is not cleared.
module mac_grid_divergence_stencil
    import mgd_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int RST_W = (MAX_WIDTH < int'(GRID_SIZE_RST)) ? MAX_WIDTH : int'(GRID_SIZE_RST);
    localparam int RST_H = (MAX_HEIGHT < int'(GRID_SIZE_RST)) ? MAX_HEIGHT
                                                              : int'(GRID_SIZE_RST);
    localparam logic [COL_W-1:0] COL_LAST_RST = COL_W'(RST_W - 1);
    localparam logic [ROW_W-1:0] ROW_LAST_RST = ROW_W'(RST_H - 1);

    // Pending results of the word in the stencil stage.
    localparam int MASK_A = 0;  // cell of the previous row, same column
    localparam int MASK_B = 1;  // last row, previous column
    localparam int MASK_C = 2;  // last row, last column

    // Configuration.
    logic [COL_W-1:0]      r_col_last;
    logic [ROW_W-1:0]      r_row_last;
    logic [31:0]           r_inv_cell_size;
    logic [COL_W-1:0]      n_col_last;
    logic [ROW_W-1:0]      n_row_last;
    logic [CFG_SIZE_W-1:0] w_cfg_size;
    logic                  w_cfg_we;
    logic                  w_restart;

    // Raster position.
    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;
    logic [COL_W-1:0]      n_col;
    logic [ROW_W-1:0]      n_row;

    // Stencil stage.
    logic [2:0]            r_s1_mask;
    t_in_word              r_s1_in;
    t_line_word            r_s1_up;
    logic [1:0]            r_held_kind;
    logic signed [31:0]    r_held_vx;
    logic signed [31:0]    r_held_vy;
    logic [1:0]            r_held_up_left;
    logic [1:0]            r_held_kind2;
    logic [COL_W-1:0]      r_s1_col;
    logic [ROW_W-1:0]      r_s1_row;
    logic                  r_s1_has_left;
    logic                  r_s1_has_right;
    logic                  r_s1_has_down;
    logic                  r_s1_b_has_left;

    // Sum stage.
    logic                  r_s2_valid;
    t_div_req              r_s2_req;

    logic                  w_accept;
    logic                  w_issue;
    logic                  w_s2_free;
    logic                  w_scale_ready;
    logic [2:0]            w_pick;
    logic [2:0]            w_mask_rest;
    logic [2:0]            n_mask;
    logic                  w_last_row;
    logic [COL_W-1:0]      w_next_col;
    t_line_word            w_line_wr;
    t_line_word            w_line_rd;
    t_div_req              n_req;

    // Operands of the selected result.
    logic [1:0]            w_k;
    logic signed [31:0]    w_vx;
    logic signed [31:0]    w_vy;
    logic                  w_has_l;
    logic [1:0]            w_lk;
    logic                  w_has_r;
    logic [1:0]            w_rk;
    logic signed [31:0]    w_rvx;
    logic                  w_has_d;
    logic [1:0]            w_dk;
    logic                  w_has_u;
    logic [1:0]            w_uk;
    logic signed [31:0]    w_uvy;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid;
    assign w_cfg_size  = i_cfg_data[CFG_SIZE_W-1:0];
    assign w_restart   = w_cfg_we &&
                         (i_cfg_index == CFG_GRID_WIDTH || i_cfg_index == CFG_GRID_HEIGHT);

    // Grid sizes are clamped to the supported range and kept as last index.
    always_comb begin
        if (w_cfg_size < CFG_SIZE_W'(2)) begin
            n_col_last = COL_W'(1);
        end else if (32'(w_cfg_size) > 32'(MAX_WIDTH)) begin
            n_col_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            n_col_last = COL_W'(w_cfg_size - CFG_SIZE_W'(1));
        end
        if (w_cfg_size < CFG_SIZE_W'(2)) begin
            n_row_last = ROW_W'(1);
        end else if (32'(w_cfg_size) > 32'(MAX_HEIGHT)) begin
            n_row_last = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            n_row_last = ROW_W'(w_cfg_size - CFG_SIZE_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last      <= COL_LAST_RST;
            r_row_last      <= ROW_LAST_RST;
            r_inv_cell_size <= INV_CELL_SIZE_RST;
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:    r_col_last      <= n_col_last;
                CFG_GRID_HEIGHT:   r_row_last      <= n_row_last;
                CFG_INV_CELL_SIZE: r_inv_cell_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input handshake and raster position
    // ------------------------------------------------------------------
    assign w_mask_rest = r_s1_mask & ~w_pick;
    assign w_s2_free   = !r_s2_valid || w_scale_ready;
    assign w_issue     = (r_s1_mask != 3'b000) && w_s2_free;
    assign o_in_ready  = (r_s1_mask == 3'b000) || (w_issue && w_mask_rest == 3'b000);
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_last_row  = (r_row == r_row_last);
    assign w_next_col  = (r_col == r_col_last) ? '0 : r_col + COL_W'(1);

    always_comb begin
        n_col = w_next_col;
        n_row = r_row;
        if (r_col == r_col_last) begin
            n_row = w_last_row ? '0 : r_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // Line store: written at this column, read one column ahead
    // ------------------------------------------------------------------
    assign w_line_wr.older_kind = w_line_rd.kind;
    assign w_line_wr.kind       = i_in_data.cell_kind;
    assign w_line_wr.vel_x      = i_in_data.face_vel_x;
    assign w_line_wr.vel_y      = i_in_data.face_vel_y;

    mgd_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept),
        .i_wr_addr (r_col),
        .i_wr_data (w_line_wr),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_next_col),
        .o_rd_data (w_line_rd)
    );

    // ------------------------------------------------------------------
    // Stencil stage: capture the word, its upper cell and the held row cells
    // ------------------------------------------------------------------
    always_comb begin
        n_mask         = 3'b000;
        n_mask[MASK_A] = (r_row != '0);
        n_mask[MASK_B] = w_last_row && (r_col != '0);
        n_mask[MASK_C] = w_last_row && (r_col == r_col_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_mask <= 3'b000;
        end else if (w_accept) begin
            r_s1_mask <= n_mask;
        end else if (w_issue) begin
            r_s1_mask <= w_mask_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_in         <= i_in_data;
            r_s1_up         <= w_line_rd;
            r_held_kind     <= r_s1_in.cell_kind;
            r_held_vx       <= r_s1_in.face_vel_x;
            r_held_vy       <= r_s1_in.face_vel_y;
            r_held_up_left  <= r_s1_up.kind;
            r_held_kind2    <= r_held_kind;
            r_s1_col        <= r_col;
            r_s1_row        <= r_row;
            r_s1_has_left   <= (r_col != '0);
            r_s1_has_right  <= (r_col != r_col_last);
            r_s1_has_down   <= (r_row > ROW_W'(1));
            r_s1_b_has_left <= (r_col > COL_W'(1));
        end
    end

    // Results leave in order: previous-row cell, then left cell, then this cell.
    always_comb begin
        w_pick = 3'b000;
        if (r_s1_mask[MASK_A]) begin
            w_pick[MASK_A] = 1'b1;
        end else if (r_s1_mask[MASK_B]) begin
            w_pick[MASK_B] = 1'b1;
        end else if (r_s1_mask[MASK_C]) begin
            w_pick[MASK_C] = 1'b1;
        end
    end

    // Operand select for the chosen cell.
    always_comb begin
        w_k     = r_s1_in.cell_kind;
        w_vx    = r_s1_in.face_vel_x;
        w_vy    = r_s1_in.face_vel_y;
        w_has_l = 1'b1;
        w_lk    = r_held_kind;
        w_has_r = 1'b0;
        w_rk    = r_s1_in.cell_kind;
        w_rvx   = r_s1_in.face_vel_x;
        w_has_d = 1'b1;
        w_dk    = r_s1_up.kind;
        w_has_u = 1'b0;
        w_uk    = r_s1_in.cell_kind;
        w_uvy   = r_s1_in.face_vel_y;
        n_req.col  = POS_W'(r_s1_col);
        n_req.row  = POS_W'(r_s1_row);
        n_req.last = 1'b1;
        if (w_pick[MASK_A]) begin
            // Cell of the previous row; the new word is its upper neighbor.
            w_k     = r_s1_up.kind;
            w_vx    = r_s1_up.vel_x;
            w_vy    = r_s1_up.vel_y;
            w_has_l = r_s1_has_left;
            w_lk    = r_held_up_left;
            w_has_r = r_s1_has_right;
            w_rk    = w_line_rd.kind;
            w_rvx   = w_line_rd.vel_x;
            w_has_d = r_s1_has_down;
            w_dk    = r_s1_up.older_kind;
            w_has_u = 1'b1;
            n_req.row  = POS_W'(r_s1_row - ROW_W'(1));
            n_req.last = 1'b0;
        end else if (w_pick[MASK_B]) begin
            // Previous cell of the last row; the new word is its right neighbor.
            w_k     = r_held_kind;
            w_vx    = r_held_vx;
            w_vy    = r_held_vy;
            w_has_l = r_s1_b_has_left;
            w_lk    = r_held_kind2;
            w_has_r = 1'b1;
            w_dk    = r_held_up_left;
            n_req.col  = POS_W'(r_s1_col - COL_W'(1));
            n_req.last = 1'b0;
        end
        n_req.sum = cell_sum(w_k, w_vx, w_vy, w_has_l, w_lk, w_has_r, w_rk, w_rvx,
                             w_has_d, w_dk, w_has_u, w_uk, w_uvy);
    end

    // ------------------------------------------------------------------
    // Sum register feeding the scaling pipeline
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_issue) begin
            r_s2_valid <= 1'b1;
        end else if (w_scale_ready) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s2_req <= n_req;
        end
    end

    mgd_scale u_scale (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_inv_cell_size (r_inv_cell_size),
        .i_req_valid     (r_s2_valid),
        .o_req_ready     (w_scale_ready),
        .i_req           (r_s2_req),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_data      (o_out_data)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The raster position never leaves the configured grid.
    a_pos_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= r_col_last) && (r_row <= r_row_last))
        else $error("raster position outside the grid");

    // A result taken from the stencil stage is held in the sum register.
    a_issue_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |=> r_s2_valid)
        else $error("issued result lost before the scaling pipeline");

    // The final result of a grid belongs to its top-right cell.
    a_last_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_last) |->
        (o_out_data.out_col == POS_W'(r_col_last)) &&
        (o_out_data.out_row == POS_W'(r_row_last)))
        else $error("frame end flagged on the wrong cell");

endmodule

[rtl/core/mgd_line_store.sv]
// ============================================================================
// mgd_line_store
// One-row line store: one write port and one registered read port.
// ============================================================================
module mgd_line_store
    import mgd_pkg::*;
#(
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_line_word        i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_line_word        o_rd_data
);

    t_line_word r_mem [0:DEPTH-1];
    t_line_word r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds until the next enabled read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/mgd_scale.sv]
// ============================================================================
// mgd_scale
// Scales a divergence sum by the inverse cell size, negates and saturates.
// ============================================================================
module mgd_scale
    import mgd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_inv_cell_size,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  t_div_req    i_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_data
);

    localparam int PROD_W = SUM_W + 16;
    localparam int ACC_W  = PROD_W + 1;

    logic                r_p_valid;
    logic                r_p_pos;
    logic [PROD_W-1:0]   r_p_hi;
    logic [PROD_W-1:0]   r_p_lo;
    logic [POS_W-1:0]    r_p_col;
    logic [POS_W-1:0]    r_p_row;
    logic                r_p_last;
    logic                r_out_valid;
    t_out_word           r_out;

    logic                w_out_free;
    logic                w_p_free;
    logic [SUM_W-1:0]    w_mag;
    logic [PROD_W-1:0]   n_p_hi;
    logic [PROD_W-1:0]   n_p_lo;
    logic [ACC_W-1:0]    w_m;
    logic signed [31:0]  w_div;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_p_free    = !r_p_valid || w_out_free;
    assign o_req_ready = w_p_free;

    // Magnitude times the integer and fraction halves of the scale.
    assign w_mag  = i_req.sum[SUM_W-1] ? $unsigned(-i_req.sum) : $unsigned(i_req.sum);
    assign n_p_hi = PROD_W'(w_mag) * PROD_W'(i_inv_cell_size[31:16]);
    assign n_p_lo = PROD_W'(w_mag) * PROD_W'(i_inv_cell_size[15:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (i_req_valid && w_p_free) begin
            r_p_valid <= 1'b1;
        end else if (w_out_free) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && w_p_free) begin
            r_p_pos  <= !i_req.sum[SUM_W-1] && (i_req.sum != '0);
            r_p_hi   <= n_p_hi;
            r_p_lo   <= n_p_lo;
            r_p_col  <= i_req.col;
            r_p_row  <= i_req.row;
            r_p_last <= i_req.last;
        end
    end

    // Truncated product, then the sign flip with saturation.
    assign w_m = ACC_W'(r_p_hi) + ACC_W'(r_p_lo[PROD_W-1:16]);

    always_comb begin
        if (r_p_pos) begin
            if (w_m > ACC_W'(32'h8000_0000)) begin
                w_div = 32'sh8000_0000;
            end else begin
                w_div = $signed(32'd0 - w_m[31:0]);
            end
        end else begin
            if (w_m > ACC_W'(32'h7FFF_FFFF)) begin
                w_div = 32'sh7FFF_FFFF;
            end else begin
                w_div = $signed(w_m[31:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_p_valid && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p_valid && w_out_free) begin
            r_out.out_col    <= r_p_col;
            r_out.out_row    <= r_p_row;
            r_out.divergence <= w_div;
            r_out.frame_last <= r_p_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[bench/mac_grid_divergence_stencil_tb.sv]
// ============================================================================
// mac_grid_divergence_stencil_tb
// Self-checking bench for the streaming grid divergence stencil. A short table
// of hand-picked cells and register writes runs first. Random grids of many
// shapes and scales follow, then the widest and the tallest grid. Every result
// word is checked field by field against an in-bench model of the line stores
// and the stencil, or a pinned divergence. Both channels idle in random bursts, except near the end.
// ============================================================================
module mac_grid_divergence_stencil_tb;
    import mgd_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int MAX_H        = 1024;
    localparam int DRAIN_CYCLES = 8;
    localparam int RAND_ITEMS   = 300;
    localparam int EDGE_ITEMS   = 48;
    localparam int DIR_N        = 26;
    localparam longint LIMIT_TIME = 64'd16_000_000;

    // Kinds that are neither fluid nor wall, and the unused register index.
    localparam logic [1:0]           KIND_OTHER    = 2'd2;
    localparam logic [1:0]           KIND_SPARE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef enum logic {ROW_CFG, ROW_CELL} t_row_op;
    typedef enum logic {CHK_MODEL, CHK_PINNED} t_row_chk;

    // One row of the directed table: a register write or a cell word.
    typedef struct packed {
        t_row_op     op;
        logic [1:0]  sel;
        logic [31:0] a;
        logic [31:0] b;
        t_row_chk    chk;
        logic [31:0] want_div;
    } t_dir_row;

    // Neighbors carried from the previous cell of the row.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [1:0]         up_left;
    } t_held_cell;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_word              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_word             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit          idle_en = 1'b1;
    int unsigned stall_left = 0;
    int unsigned err_cnt = 0;

    // Model state: registers, counters, held cell and line stores.
    logic [CFG_SIZE_W-1:0] width_q;
    logic [CFG_SIZE_W-1:0] height_q;
    logic [31:0]           scale_q;
    int                    col_q;
    int                    row_q;
    t_held_cell            held_q;
    logic [1:0]            prev_kind [0:MAX_W-1];
    logic signed [31:0]    prev_vx   [0:MAX_W-1];
    logic signed [31:0]    prev_vy   [0:MAX_W-1];
    logic [1:0]            older_kind [0:MAX_W-1];

    t_out_word divergence_q [$];

    // Directed cells on a 2 x 2 grid: plain sums, walls, odd kinds,
    // saturation, a zero scale and a restart in the middle of a frame.
    t_dir_row dir_tab [DIR_N] = '{
        '{ROW_CFG,  CFG_GRID_WIDTH,    32'd1,        32'd0,        CHK_MODEL,  32'd0},
        '{ROW_CFG,  CFG_GRID_HEIGHT,   32'd0,        32'd0,        CHK_MODEL,  32'd0},
        '{ROW_CELL, KIND_FLUID,        32'h0001_0000, 32'h0000_0000, CHK_MODEL, 32'd0},
        '{ROW_CELL, KIND_FLUID,        32'h0003_0000, 32'h0000_0000, CHK_MODEL, 32'd0},
        '{ROW_CELL, KIND_FLUID,        32'h0000_0000, 32'h0002_0000, CHK_PINNED,
          32'hFFFC_0000},
        '{ROW_CELL, KIND_WALL,         32'h7FFF_FFFF, 32'h8000_0000, CHK_PINNED, 32'd0},
        '{ROW_CFG,  CFG_INV_CELL_SIZE, 32'h0002_0000, 32'd0,        CHK_MODEL,  32'd0},
        '{ROW_CELL, KIND_WALL,         32'h0005_0000, 32'h0001_0000, CHK_MODEL, 32'd0},
        '{ROW_CELL, KIND_FLUID,        32'h0002_0000, 32'hFFFF_0000, CHK_MODEL, 32'd0},
        '{ROW_CELL, KIND_SPARE,        32'h1234_5678, 32'h0004_0000, CHK_PINNED, 32'd0},
        '{ROW_CELL, KIND_FLUID,        32'hFFFE_0000, 32'h0000_8000, CHK_MODEL, 32'd0},
        '{ROW_CFG,  CFG_INV_CELL_SIZE, 32'hFFFF_FFFF, 32'd0,        CHK_MODEL,  32'd0},
        '{ROW_CELL, KIND_FLUID,        32'h8000_0000, 32'h8000_0000, CHK_MODEL, 32'd0},
        '{ROW_CELL, KIND_FLUID,        32'h7FFF_FFFF, 32'h7FFF_FFFF, CHK_MODEL, 32'd0},
        '{ROW_CELL, KIND_FLUID,        32'h7FFF_FFFF, 32'h7FFF_FFFF, CHK_PINNED,
          32'h8000_0000},
        '{ROW_CELL, KIND_FLUID,        32'h8000_0000, 32'h8000_0000, CHK_MODEL, 32'd0},
        '{ROW_CELL, KIND_OTHER,        32'h0000_ABCD, 32'hFFFF_1234, CHK_MODEL, 32'd0},
        '{ROW_CELL, KIND_FLUID,        32'h0000_1000, 32'hFFFF_F000, CHK_MODEL, 32'd0},
        '{ROW_CELL, KIND_WALL,         32'h0022_0000, 32'h0033_0000, CHK_MODEL, 32'd0},
        '{ROW_CFG,  CFG_GRID_WIDTH,    32'd1,        32'd0,        CHK_MODEL,  32'd0},
        '{ROW_CFG,  CFG_INV_CELL_SIZE, 32'h0000_0000, 32'd0,        CHK_MODEL,  32'd0},
        '{ROW_CFG,  CFG_IDX_SPARE,     32'h0001_0000, 32'd0,        CHK_MODEL,  32'd0},
        '{ROW_CELL, KIND_FLUID,        32'h0001_1111, 32'hFFFF_0000, CHK_MODEL, 32'd0},
        '{ROW_CELL, KIND_FLUID,        32'h7FFF_FFFF, 32'h1234_5678, CHK_MODEL, 32'd0},
        '{ROW_CELL, KIND_FLUID,        32'h8000_0000, 32'h0000_0001, CHK_PINNED, 32'd0},
        '{ROW_CELL, KIND_FLUID,        32'h0001_0000, 32'h7FFF_FFFF, CHK_PINNED, 32'd0}
    };

    mac_grid_divergence_stencil dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Free-running clock.
    initial begin
        forever #4 clk = ~clk;
    end

    // Grid sizes below two act as two, above the store depth as the maximum.
    function automatic int grid_dim(input logic [CFG_SIZE_W-1:0] v, input int maxv);
        if (v < 2) return 2;
        if (int'(v) > maxv) return maxv;
        return int'(v);
    endfunction

    // Face velocity differences around one cell; non-fluid cells give zero.
    function automatic longint face_flux_sum(
        input logic [1:0] k, input longint vx, input longint vy,
        input bit has_l, input logic [1:0] lk,
        input bit has_r, input logic [1:0] rk, input longint rvx,
        input bit has_d, input logic [1:0] dk,
        input bit has_u, input logic [1:0] uk, input longint uvy
    );
        longint d;
        d = 0;
        if (k != KIND_FLUID) return 0;
        if (has_l && lk == KIND_WALL) d += vx;
        if (has_r) begin
            d += rvx - vx;
            if (rk == KIND_WALL) d -= rvx;
        end
        if (has_d && dk == KIND_WALL) d += vy;
        if (has_u) begin
            d += uvy - vy;
            if (uk == KIND_WALL) d -= uvy;
        end
        return d;
    endfunction

    // Scale the magnitude by the reciprocal cell size, negate and saturate.
    function automatic logic [31:0] scale_negate(input longint d);
        longint unsigned mag;
        longint unsigned ih;
        longint unsigned il;
        longint unsigned m;
        mag = (d < 0) ? -d : d;
        ih  = scale_q >> 16;
        il  = scale_q & 32'h0000_FFFF;
        m   = mag * ih + ((mag * il) >> 16);
        if (d > 0) begin
            if (m > 64'h8000_0000) return 32'h8000_0000;
            return 32'(~m + 64'd1);
        end
        if (m > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return m[31:0];
    endfunction

    function automatic void push_div(input int col, input int row,
                                     input logic [31:0] dv, input bit last);
        t_out_word res;
        res.out_col    = col[POS_W-1:0];
        res.out_row    = row[POS_W-1:0];
        res.divergence = dv;
        res.frame_last = last;
        divergence_q.insert(divergence_q.size(), res);
    endfunction

    // Register write as the block sees it; size writes restart the frame.
    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [31:0] data);
        case (idx)
            CFG_GRID_WIDTH: begin
                width_q = data[CFG_SIZE_W-1:0];
                col_q = 0; row_q = 0; held_q = '0;
            end
            CFG_GRID_HEIGHT: begin
                height_q = data[CFG_SIZE_W-1:0];
                col_q = 0; row_q = 0; held_q = '0;
            end
            CFG_INV_CELL_SIZE: begin
                scale_q = data;
            end
            default: begin
            end
        endcase
    endfunction

    // Consume one cell word and queue the divergence words it completes.
    function automatic void stencil_step(input t_in_word in_w);
        int         w;
        int         h;
        int         c;
        int         r;
        logic [1:0] k;
        logic [1:0] old_up;
        longint     vx;
        longint     vy;
        w  = grid_dim(width_q, MAX_W);
        h  = grid_dim(height_q, MAX_H);
        c  = col_q;
        r  = row_q;
        k  = in_w.cell_kind;
        vx = longint'(in_w.face_vel_x);
        vy = longint'(in_w.face_vel_y);
        if (c >= w || r >= h) begin
            c = 0;
            r = 0;
        end
        old_up = prev_kind[c];

        // The cell of the previous row in this column is now complete.
        if (r >= 1) begin
            push_div(c, r - 1, scale_negate(face_flux_sum(
                prev_kind[c], prev_vx[c], prev_vy[c],
                c > 0, held_q.up_left,
                c + 1 < w, (c + 1 < w) ? prev_kind[c + 1] : KIND_FLUID,
                (c + 1 < w) ? longint'(prev_vx[c + 1]) : 0,
                r > 1, older_kind[c],
                1'b1, k, vy)), 1'b0);
        end
        // In the last row the cell to the left is complete too.
        if (r == h - 1 && c >= 1) begin
            push_div(c - 1, r, scale_negate(face_flux_sum(
                held_q.kind, held_q.vx, held_q.vy,
                c > 1, (c >= 2) ? prev_kind[c - 2] : KIND_FLUID,
                1'b1, k, vx,
                1'b1, older_kind[c - 1],
                1'b0, KIND_FLUID, 0)), 1'b0);
        end
        // The very last cell flushes itself.
        if (r == h - 1 && c == w - 1) begin
            push_div(c, r, scale_negate(face_flux_sum(
                k, vx, vy,
                1'b1, prev_kind[c - 1],
                1'b0, KIND_FLUID, 0,
                1'b1, old_up,
                1'b0, KIND_FLUID, 0)), 1'b1);
        end

        held_q.up_left = old_up;
        held_q.kind    = k;
        held_q.vx      = in_w.face_vel_x;
        held_q.vy      = in_w.face_vel_y;
        older_kind[c]  = old_up;
        prev_kind[c]   = k;
        prev_vx[c]     = in_w.face_vel_x;
        prev_vy[c]     = in_w.face_vel_y;

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_q = c;
        row_q = r;
    endfunction

    function automatic logic [31:0] rand_vel();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0, 1, 2: v = 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
            3, 4, 5: v = $urandom;
            6: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: v = 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
        endcase
        return v;
    endfunction

    // Mostly fluid cells with walls and odd kinds sprinkled in.
    function automatic t_in_word rand_cell();
        t_in_word gen_w;
        int       pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) gen_w.cell_kind = KIND_FLUID;
        else if (pick < 8) gen_w.cell_kind = KIND_WALL;
        else if (pick == 8) gen_w.cell_kind = KIND_OTHER;
        else gen_w.cell_kind = KIND_SPARE;
        gen_w.face_vel_x = rand_vel();
        gen_w.face_vel_y = rand_vel();
        return gen_w;
    endfunction

    function automatic logic [31:0] pick_scale();
        logic [31:0] s;
        case ($urandom_range(0, 5))
            0: s = 32'h0000_0000;
            1: s = 32'hFFFF_FFFF;
            2: s = INV_CELL_SIZE_RST;
            3: s = $urandom;
            4: s = 32'($urandom_range(0, 32'h0004_0000));
            default: s = 32'($urandom_range(32'h100, 32'h8000));
        endcase
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        err_cnt++;
        if (err_cnt <= 40) begin
            $display("mismatch on %s: expected %h, got %h", what, want, got);
        end
    endtask

    // Write one register once every expected word is out and the pipe is empty.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        in_valid <= 1'b0;
        while (divergence_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        apply_cfg(idx, data);
    endtask

    // Offer one cell word; valid stays high until it is taken.
    task automatic send_cell(input t_in_word in_w, input bit pin_div,
                             input logic [31:0] pinned);
        int unsigned gap;
        int          first;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= in_w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        first = divergence_q.size();
        stencil_step(in_w);
        if (pin_div) begin
            for (int i = first; i < divergence_q.size(); i++) begin
                divergence_q[i].divergence = pinned;
            end
        end
    endtask

    // One grid setting followed by a run of random cells.
    task automatic run_phase(input bit set_size, input logic [CFG_SIZE_W-1:0] wv,
                             input logic [CFG_SIZE_W-1:0] hv, input bit set_scale,
                             input logic [31:0] scale, input int unsigned n_items);
        if (set_size) begin
            write_reg(CFG_GRID_WIDTH, 32'(wv));
            write_reg(CFG_GRID_HEIGHT, 32'(hv));
        end
        if (set_scale) write_reg(CFG_INV_CELL_SIZE, scale);
        if ($urandom_range(0, 5) == 0) write_reg(CFG_IDX_SPARE, $urandom);
        repeat (n_items) send_cell(rand_cell(), 1'b0, 32'd0);
    endtask

    // Result side stalls in random bursts while idling is enabled.
    always @(posedge clk) begin
        if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 18);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Check each accepted result word against the oldest expectation.
    always @(posedge clk) begin
        t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (divergence_q.size() == 0) begin
                report_mismatch("word with nothing expected", 32'd0,
                                {out_data.out_col, out_data.out_row, 12'd0});
            end else begin
                want = divergence_q.pop_front();
                if (out_data.out_col !== want.out_col)
                    report_mismatch("out_col", 32'(want.out_col), 32'(out_data.out_col));
                if (out_data.out_row !== want.out_row)
                    report_mismatch("out_row", 32'(want.out_row), 32'(out_data.out_row));
                if (out_data.divergence !== want.divergence)
                    report_mismatch("divergence", want.divergence, out_data.divergence);
                if (out_data.frame_last !== want.frame_last)
                    report_mismatch("frame_last", 32'(want.frame_last),
                                    32'(out_data.frame_last));
            end
        end
    end

    // Stimulus: reset, directed table, random grids, extremes, quiet tail.
    initial begin
        int unsigned rand_items;
        int unsigned n;
        int          we;
        int          he;
        bit          set_size;
        logic [CFG_SIZE_W-1:0] wv;
        logic [CFG_SIZE_W-1:0] hv;
        t_in_word    dir_w;

        width_q  = GRID_SIZE_RST;
        height_q = GRID_SIZE_RST;
        scale_q  = INV_CELL_SIZE_RST;
        col_q    = 0;
        row_q    = 0;
        held_q   = '0;
        for (int i = 0; i < MAX_W; i++) begin
            prev_kind[i]  = KIND_FLUID;
            prev_vx[i]    = '0;
            prev_vy[i]    = '0;
            older_kind[i] = KIND_FLUID;
        end
        rand_items = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].op == ROW_CFG) begin
                write_reg(dir_tab[i].sel, dir_tab[i].a);
            end else begin
                dir_w.cell_kind  = dir_tab[i].sel;
                dir_w.face_vel_x = dir_tab[i].a;
                dir_w.face_vel_y = dir_tab[i].b;
                send_cell(dir_w, dir_tab[i].chk == CHK_PINNED, dir_tab[i].want_div);
            end
        end

        // Random grids, mostly small, some wide, some sizes below the minimum.
        while (rand_items < RAND_ITEMS) begin
            idle_en  = ($urandom_range(0, 3) != 0);
            set_size = (rand_items == 0) || ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 7) == 0) begin
                wv = CFG_SIZE_W'($urandom_range(10, 40));
                hv = 2;
            end else begin
                wv = CFG_SIZE_W'($urandom_range(2, 9));
                hv = CFG_SIZE_W'($urandom_range(2, 6));
            end
            if ($urandom_range(0, 9) == 0) wv = CFG_SIZE_W'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) hv = CFG_SIZE_W'($urandom_range(0, 1));
            we = grid_dim(set_size ? wv : width_q, MAX_W);
            he = grid_dim(set_size ? hv : height_q, MAX_H);
            n  = we * he * $urandom_range(1, 2);
            if ($urandom_range(0, 2) == 0) n += $urandom_range(1, we * he - 1);
            if (n > RAND_ITEMS - rand_items) n = RAND_ITEMS - rand_items;
            run_phase(set_size, wv, hv, $urandom_range(0, 1) == 1, pick_scale(), n);
            rand_items += n;
        end

        // Widest grid (written above the maximum) and tallest grid, first rows.
        idle_en = 1'b1;
        run_phase(1'b1, 11'h7FF, 11'd2, 1'b1, pick_scale(), EDGE_ITEMS);
        run_phase(1'b1, 11'd2, 11'd1024, 1'b1, pick_scale(), EDGE_ITEMS);

        // Quiet tail with both sides always ready.
        idle_en = 1'b0;
        run_phase(1'b1, 11'd5, 11'd4, 1'b1, pick_scale(), 5 * 4 * 2 + 7);

        in_valid <= 1'b0;
        while (divergence_q.size() != 0) @(posedge clk);
        repeat (4 * DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard stop if the run hangs.
    initial begin
        #(LIMIT_TIME);
        $display("tb: failure");
        $finish;
    end

endmodule
